>>> src/pcbd_pkg.sv
`timescale 1ns / 1ps

package pcbd_pkg;

	// operation field codes
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		ST_SYMBOL    = 2'd0,
		ST_NO_MATCH  = 2'd1,
		ST_TRUNCATED = 2'd2
	} status_t;

	// decoder sequencer
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_EMIT
	} state_t;

	// one table slot as held in the slot memory
	typedef struct packed {
		logic [7:0]  symbol;
		logic [15:0] code;
		logic [4:0]  length;
	} entry_t;

endpackage

>>> src/pcbd_item_if.sv
`timescale 1ns / 1ps

interface pcbd_item_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [4:0]  entry_slot;
	logic [7:0]  entry_symbol;
	logic [15:0] entry_code;
	logic [4:0]  entry_length;
	logic        code_bit;
	logic        end_of_message;

	modport source (
		output valid, operation, entry_slot, entry_symbol, entry_code,
		       entry_length, code_bit, end_of_message,
		input  ready
	);
	modport sink (
		input  valid, operation, entry_slot, entry_symbol, entry_code,
		       entry_length, code_bit, end_of_message,
		output ready
	);
endinterface

>>> src/pcbd_result_if.sv
`timescale 1ns / 1ps

interface pcbd_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] decoded_symbol;
	logic [1:0] status;
	logic       at_message_end;

	modport source (
		output valid, decoded_symbol, status, at_message_end,
		input  ready
	);
	modport sink (
		input  valid, decoded_symbol, status, at_message_end,
		output ready
	);
endinterface

>>> src/prefix_code_bit_decoder.sv
`timescale 1ns / 1ps

// Prefix-code (Huffman) bit decoder.
// Input channel "item": a load word (operation = load) writes one table slot
// with symbol, code and length; length 0 empties the slot, slots at or above
// NUM_SLOTS are ignored. A decode word (operation = decode) appends code_bit
// to the code accumulator and then looks the code up in the table.
// Output channel "res": one word per decode bit that completes a symbol,
// overruns MAX_CODE_BITS without a match, or ends a message mid-code.
// Lookup: a decode word is taken in the idle step, then the single read
// port of the slot memory is walked once over every slot, one slot per
// cycle, a drain step empties the read register and an emit step issues
// the result. No word is taken while a lookup is in flight, so table
// writes never race a scan.
// The result sits in an output register: the next word is accepted while it
// waits. If the receiver stalls and a second result is ready, the block
// holds in its emit step until the register frees up.
// Reset empties the whole table at once (one valid flop per slot) and
// clears the accumulator, bit count and output valid.
module prefix_code_bit_decoder #(
	parameter int NUM_SLOTS     = 32,
	parameter int MAX_CODE_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	pcbd_item_if.sink      item,
	pcbd_result_if.source  res
);
	import pcbd_pkg::*;

	localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = $clog2(MAX_CODE_BITS + 1);

	// slot memory, valid flags and read stage
	entry_t                  tbl_mem [NUM_SLOTS];
	logic [NUM_SLOTS-1:0]    vld_q;
	entry_t                  rd_s1;
	logic                    vld_s1;
	logic                    cmp_en_s1;

	// code accumulator
	logic [MAX_CODE_BITS-1:0] acc_q;
	logic [CW-1:0]            cnt_q;
	logic [MAX_CODE_BITS-1:0] cnt_mask;
	logic [MAX_CODE_BITS-1:0] code_ext;

	// lookup state
	state_t        state_q, state_d;
	logic [AW-1:0] scan_q;
	logic          found_q;
	logic [7:0]    hit_sym_q;
	logic          eom_q;

	// output register
	logic          res_valid_q;
	logic [7:0]    res_sym_q;
	status_t       res_status_q;
	logic          res_end_q;

	// control from the sequencer
	logic          accept;
	logic          wr_en;
	logic          rd_en;
	logic          emit_load;
	logic          acc_clear;
	logic          has_res;
	logic          out_free;
	logic          slot_match;
	logic          overrun;
	logic [AW-1:0] wr_addr;

	assign accept   = item.valid && item.ready;
	assign wr_en    = accept && (item.operation == OP_LOAD) &&
	                  (32'(item.entry_slot) < NUM_SLOTS);
	assign wr_addr  = AW'(item.entry_slot);
	assign overrun  = 32'(cnt_q) >= MAX_CODE_BITS;
	assign has_res  = found_q || overrun || eom_q;
	assign out_free = !res_valid_q || res.ready;

	// bits gathered so far
	always_comb begin
		for (int k = 0; k < MAX_CODE_BITS; k++) begin
			cnt_mask[k] = (32'(cnt_q) > k);
		end
	end

	// code bits above bit 15 read as zero
	assign code_ext   = MAX_CODE_BITS'(rd_s1.code);
	assign slot_match = vld_s1 && (rd_s1.length != 5'd0) &&
	                    (32'(rd_s1.length) == 32'(cnt_q)) &&
	                    ((code_ext & cnt_mask) == acc_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		item.ready = 1'b0;
		rd_en      = 1'b0;
		emit_load  = 1'b0;
		acc_clear  = 1'b0;
		case (state_q)
			S_IDLE: begin
				item.ready = 1'b1;
				if (item.valid && (item.operation == OP_DECODE)) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				rd_en = 1'b1;
				if (scan_q == AW'(NUM_SLOTS - 1)) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (!has_res) begin
					state_d = S_IDLE;
				end else if (out_free) begin
					emit_load = 1'b1;
					acc_clear = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			tbl_mem[wr_addr] <= '{symbol: item.entry_symbol, code: item.entry_code,
			                      length: item.entry_length};
		end
		if (rd_en) begin
			rd_s1  <= tbl_mem[scan_q];
			vld_s1 <= vld_q[scan_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			cmp_en_s1 <= 1'b0;
			scan_q    <= '0;
			found_q   <= 1'b0;
			acc_q     <= '0;
			cnt_q     <= '0;
			eom_q     <= 1'b0;
		end else begin
			cmp_en_s1 <= rd_en;
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (accept && (item.operation == OP_DECODE)) begin
				// count is always below MAX_CODE_BITS here
				acc_q   <= acc_q | (MAX_CODE_BITS'(item.code_bit) << cnt_q);
				cnt_q   <= cnt_q + CW'(1);
				eom_q   <= item.end_of_message;
				scan_q  <= '0;
				found_q <= 1'b0;
			end else begin
				if (rd_en) begin
					scan_q <= scan_q + AW'(1);
				end
				// ascending scan: the last hit is the highest slot
				if (cmp_en_s1 && slot_match) begin
					found_q <= 1'b1;
				end
				if (acc_clear) begin
					acc_q <= '0;
					cnt_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_en_s1 && slot_match) begin
			hit_sym_q <= rd_s1.symbol;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			res_end_q <= eom_q;
			if (found_q) begin
				res_sym_q    <= hit_sym_q;
				res_status_q <= ST_SYMBOL;
			end else if (overrun) begin
				res_sym_q    <= 8'd0;
				res_status_q <= ST_NO_MATCH;
			end else begin
				res_sym_q    <= 8'd0;
				res_status_q <= ST_TRUNCATED;
			end
		end
	end

	assign res.valid          = res_valid_q;
	assign res.decoded_symbol = res_sym_q;
	assign res.status         = res_status_q;
	assign res.at_message_end = res_end_q;

	// checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= MAX_CODE_BITS)
		else $error("bit count beyond maximum code length");

	a_acc_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_q & ~cnt_mask) == '0)
		else $error("accumulator holds bits beyond the count");

	a_cmp_window: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_en_s1 |-> (state_q == S_SCAN || state_q == S_DRAIN))
		else $error("slot compare outside a scan");

	a_drain_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DRAIN |=> state_q == S_EMIT)
		else $error("drain not followed by emit");

	a_trunc_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (res_status_q == ST_TRUNCATED) |-> res_end_q)
		else $error("dropped code reported away from message end");

endmodule

>>> verif/prefix_code_bit_decoder_checker.sv
`timescale 1ns / 1ps

module prefix_code_bit_decoder_checker #(
	parameter int NUM_SLOTS     = 32,
	parameter int MAX_CODE_BITS = 16
) (
	input  logic   clk,
	input  logic   arst_n,
	pcbd_item_if   item,
	pcbd_result_if res,
	output int     fails,
	output int     pending
);

	import pcbd_pkg::*;

	typedef struct packed {
		logic [7:0] symbol;
		status_t    status;
		logic       at_end;
	} outcome_t;

	// shadow of the slot table and of the code being gathered
	logic [7:0]  slot_sym  [NUM_SLOTS];
	logic [15:0] slot_bits [NUM_SLOTS];
	logic [4:0]  slot_len  [NUM_SLOTS];
	logic [31:0] code_acc;
	int unsigned code_len;
	outcome_t    outcome_q [$];
	outcome_t    want;

	// one received bit: extend the code, look it up, queue any outcome
	task automatic take_bit(input logic b, input logic last);
		logic        hit;
		logic [7:0]  hit_sym;
		logic [31:0] mask;
		outcome_t    o;
		int          i;
		hit     = 1'b0;
		hit_sym = '0;
		if (code_len < 32)
			code_acc[code_len] = b;
		code_len++;
		mask = (code_len >= 32) ? '1 : ((32'd1 << code_len) - 32'd1);
		// later slots overwrite earlier hits: highest slot wins
		for (i = 0; i < NUM_SLOTS; i++) begin
			if (slot_len[i] != 0 && slot_len[i] == code_len &&
			    (({16'd0, slot_bits[i]} & mask) == (code_acc & mask))) begin
				hit     = 1'b1;
				hit_sym = slot_sym[i];
			end
		end
		if (hit) begin
			o = '{symbol: hit_sym, status: ST_SYMBOL, at_end: last};
		end else if (code_len >= MAX_CODE_BITS) begin
			o = '{symbol: 8'd0, status: ST_NO_MATCH, at_end: last};
		end else if (last) begin
			o = '{symbol: 8'd0, status: ST_TRUNCATED, at_end: 1'b1};
		end else begin
			return;
		end
		outcome_q.push_back(o);
		code_acc = '0;
		code_len = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (slot_len[i]) begin
				slot_sym[i]  = '0;
				slot_bits[i] = '0;
				slot_len[i]  = '0;
			end
			code_acc = '0;
			code_len = 0;
			outcome_q.delete();
		end else begin
			// results first: a word taken at this edge cannot have one out yet
			if (res.valid && res.ready) begin
				if (outcome_q.size() == 0) begin
					$error("unexpected result: decoded_symbol %0d status %0d end %0b",
						res.decoded_symbol, res.status, res.at_message_end);
					fails++;
				end else begin
					want = outcome_q.pop_front();
					if (res.decoded_symbol !== want.symbol) begin
						$error("decoded_symbol: expected %0d, got %0d",
							want.symbol, res.decoded_symbol);
						fails++;
					end
					if (res.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, res.status);
						fails++;
					end
					if (res.at_message_end !== want.at_end) begin
						$error("at_message_end: expected %0b, got %0b",
							want.at_end, res.at_message_end);
						fails++;
					end
				end
			end
			if (item.valid && item.ready) begin
				if (item.operation == OP_LOAD) begin
					if (item.entry_slot < NUM_SLOTS) begin
						slot_sym[item.entry_slot]  = item.entry_symbol;
						slot_bits[item.entry_slot] = item.entry_code;
						slot_len[item.entry_slot]  = item.entry_length;
					end
				end else begin
					take_bit(item.code_bit, item.end_of_message);
				end
			end
		end
		pending = outcome_q.size();
	end

endmodule

>>> verif/prefix_code_bit_decoder_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict. All prediction and comparison lives in the checker.
module prefix_code_bit_decoder_tb;

	import pcbd_pkg::*;

	localparam int NUM_SLOTS     = 32;
	localparam int MAX_CODE_BITS = 16;
	localparam int SCAN_CYCLES   = NUM_SLOTS + 3;  // one decode word, start to the next word taken
	localparam int DIRECTED      = 25;
	localparam int RANDOM_WORDS  = 425;
	localparam int CALM_TAIL     = 60;             // last words sent with no idling
	localparam int HOLD_CYCLES   = 600;            // long receiver hold-off

	logic clk;
	logic arst_n;
	int   fails;
	int   pending;
	int   words_sent;
	bit   gaps_on;
	bit   hold_req;
	bit   hold_done;

	// prefix code built for the current phase
	logic [15:0] cw_code [16];
	int          cw_len  [16];
	int          cw_num;
	bit          taken   [NUM_SLOTS];

	pcbd_item_if   item_ch ();
	pcbd_result_if res_ch ();

	prefix_code_bit_decoder #(
		.NUM_SLOTS     (NUM_SLOTS),
		.MAX_CODE_BITS (MAX_CODE_BITS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.res    (res_ch)
	);

	prefix_code_bit_decoder_checker #(
		.NUM_SLOTS     (NUM_SLOTS),
		.MAX_CODE_BITS (MAX_CODE_BITS)
	) decode_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.res     (res_ch),
		.fails   (fails),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop; a correct run is well inside this
	initial begin
		#4_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Sender side. Words change at the falling edge; a word counts as taken at
	// the rising edge where ready is seen high. Valid stays up between
	// back-to-back words and only drops for a gap or a drain.
	task automatic put_word(input logic op, input logic [4:0] slot, input logic [7:0] sym,
			input logic [15:0] code, input logic [4:0] len, input logic b, input logic eom);
		int gap;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 11);
			repeat (gap) begin
				@(negedge clk);
				item_ch.valid = 1'b0;
			end
		end
		@(negedge clk);
		item_ch.valid          = 1'b1;
		item_ch.operation      = op;
		item_ch.entry_slot     = slot;
		item_ch.entry_symbol   = sym;
		item_ch.entry_code     = code;
		item_ch.entry_length   = len;
		item_ch.code_bit       = b;
		item_ch.end_of_message = eom;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		words_sent++;
	endtask

	// the bit fields of a load word are don't-care, so fill them with noise
	task automatic load_slot(input logic [4:0] slot, input logic [7:0] sym,
			input logic [15:0] code, input logic [4:0] len);
		put_word(OP_LOAD, slot, sym, code, len, 1'($urandom), 1'($urandom));
	endtask

	// likewise the table fields of a decode word
	task automatic send_bit(input logic b, input logic eom);
		put_word(OP_DECODE, 5'($urandom), 8'($urandom), 16'($urandom), 5'($urandom), b, eom);
	endtask

	// Sends the first n bits of a code, lowest bit first. Now and then a
	// harmless load (empty or overlong length, free slot) lands mid-code to
	// show the accumulator is left alone by table writes.
	task automatic send_code(input logic [15:0] code, input int n, input bit last);
		int k;
		logic [4:0] s;
		for (k = 0; k < n; k++) begin
			if (k > 0 && $urandom_range(0, 39) == 0) begin
				s = 5'($urandom);
				while (taken[s])
					s = s + 5'd1;
				load_slot(s, 8'($urandom), 16'($urandom),
					($urandom_range(0, 1) == 0) ? 5'd0 : 5'($urandom_range(17, 31)));
			end
			send_bit(code[k], last && k == n - 1);
		end
	endtask

	// Empties most of last phase's slots, then loads a fresh, mostly
	// prefix-free code. An overlap is let through now and then so that
	// shadowed codes and equal codes in two slots (highest wins) occur.
	task automatic new_table(input int count);
		logic [15:0] c;
		int          l;
		int          m;
		int          j;
		int          tries;
		bit          clash;
		logic [4:0]  s;
		for (j = 0; j < NUM_SLOTS; j++) begin
			if (taken[j]) begin
				taken[j] = 1'b0;
				if ($urandom_range(0, 3) != 0)
					load_slot(5'(j), 8'($urandom), 16'($urandom), 5'd0);
			end
		end
		cw_num = 0;
		for (tries = 0; tries < 60 && cw_num < count; tries++) begin
			l = ($urandom_range(0, 4) == 0) ? $urandom_range(6, MAX_CODE_BITS)
			                                : $urandom_range(1, 5);
			c = 16'($urandom);
			clash = 1'b0;
			for (j = 0; j < cw_num; j++) begin
				m = (l < cw_len[j]) ? l : cw_len[j];
				if (({16'd0, c ^ cw_code[j]} & ((32'd1 << m) - 32'd1)) == 0)
					clash = 1'b1;
			end
			if (!clash || $urandom_range(0, 7) == 0) begin
				s = 5'($urandom);
				while (taken[s])
					s = s + 5'd1;
				taken[s]        = 1'b1;
				cw_code[cw_num] = c;
				cw_len[cw_num]  = l;
				cw_num++;
				load_slot(s, 8'($urandom), c, 5'(l));
			end
		end
	endtask

	// Well-formed message from the current code, with the odd stray bit
	// to knock the framing out, and sometimes a last code cut short.
	task automatic send_message(input int count);
		int k;
		int pick;
		for (k = 0; k < count; k++) begin
			pick = $urandom_range(0, cw_num - 1);
			if ($urandom_range(0, 9) == 0)
				send_bit(1'($urandom), 1'b0);
			if (k == count - 1 && $urandom_range(0, 3) == 0)
				send_code(cw_code[pick], $urandom_range(1, cw_len[pick]), 1'b1);
			else
				send_code(cw_code[pick], cw_len[pick], k == count - 1);
		end
	endtask

	// sender stops until every outstanding result is back
	task automatic drain();
		@(negedge clk);
		item_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// Receiver side: random stalls while gaps are on, and one long hold-off on
	// request so the output register and emit step both fill and the block has
	// to back-pressure its input.
	initial begin
		res_ch.ready = 1'b0;
		hold_done    = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				res_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end else if (gaps_on && $urandom_range(0, 3) == 0) begin
				res_ch.ready = 1'b0;
				repeat ($urandom_range(0, 10)) @(negedge clk);
			end else begin
				res_ch.ready = 1'b1;
			end
		end
	end

	initial begin
		int k;
		int phase;
		item_ch.valid          = 1'b0;
		item_ch.operation      = OP_LOAD;
		item_ch.entry_slot     = '0;
		item_ch.entry_symbol   = '0;
		item_ch.entry_code     = '0;
		item_ch.entry_length   = '0;
		item_ch.code_bit       = 1'b0;
		item_ch.end_of_message = 1'b0;
		words_sent = 0;
		gaps_on    = 1'b1;
		hold_req   = 1'b0;
		foreach (taken[i])
			taken[i] = 1'b0;
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Directed part.
		// Slots 0 and 8 both hold code "0": slot 8 must win. Slot 31 holds
		// "10" with every upper code bit set, slot 7 an overlong length that
		// can never match.
		load_slot(5'd0,  8'h00, 16'h0000, 5'd1);
		load_slot(5'd31, 8'hFF, 16'hFFFD, 5'd2);
		load_slot(5'd7,  8'h3C, 16'h0000, 5'd31);
		load_slot(5'd8,  8'h11, 16'h0000, 5'd1);
		send_bit(1'b0, 1'b0);
		// table write in the middle of a code, then a match on the last bit
		send_bit(1'b1, 1'b0);
		load_slot(5'd5, 8'hA5, 16'hFFFE, 5'd16);
		send_bit(1'b0, 1'b1);
		// message ends after one unmatched bit: partial code dropped
		send_bit(1'b1, 1'b1);
		// sixteen ones match nothing (slot 5 differs in bit 0): overrun on
		// the last bit of the message
		for (k = 0; k < MAX_CODE_BITS; k++)
			send_bit(1'b1, k == MAX_CODE_BITS - 1);
		taken[0]  = 1'b1;
		taken[5]  = 1'b1;
		taken[7]  = 1'b1;
		taken[8]  = 1'b1;
		taken[31] = 1'b1;

		// Random part: one code table per phase, then messages over it.
		phase = 0;
		while (words_sent < DIRECTED + RANDOM_WORDS) begin
			gaps_on = (words_sent < DIRECTED + RANDOM_WORDS - CALM_TAIL) &&
			          ($urandom_range(0, 3) != 0);
			new_table($urandom_range(2, 10));
			if (phase == 3) begin
				hold_req = 1'b1;
				send_message(12);
			end else if ($urandom_range(0, 4) == 0) begin
				// broken message: noise long enough to overrun the code length
				repeat (MAX_CODE_BITS + 2)
					send_bit(1'($urandom), 1'b0);
				send_bit(1'($urandom), 1'b1);
			end else begin
				send_message($urandom_range(3, 12));
			end
			if (phase == 5 || $urandom_range(0, 3) == 0)
				drain();
			phase++;
		end

		// wait out the last lookup, which may still be scanning
		drain();
		repeat (SCAN_CYCLES + 10) @(negedge clk);
		if (fails == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
